[rtl/rfcs_pkg.sv]
// Package for the RF channel selector with scan: payload types, event codes,
// state record, reset values and the band and segment decode tables.
// No dependencies; every other file imports it.
package rfcs_pkg;

    localparam int unsigned ELAPSED_W  = 16;
    localparam int unsigned RSSI_W     = 10;
    localparam int unsigned BAND_W     = 2;
    localparam int unsigned CHAN_W     = 3;
    localparam int unsigned SEG_W      = 7;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [ELAPSED_W-1:0] LOCKOUT_RESET = 16'd200;
    localparam logic [CHAN_W-1:0]    SCAN_LAST     = 3'd7;

    // Event codes carried in the action field.
    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_BAND = 2'd1,
        ACT_CHAN = 2'd2,
        ACT_RSSI = 2'd3
    } t_action;

    typedef struct packed {
        t_action             action;
        logic                lock_switch;
        logic [RSSI_W-1:0]   rssi_value;
    } t_in_item;

    typedef struct packed {
        logic [BAND_W-1:0]   band_pins;
        logic [CHAN_W-1:0]   channel_pins;
        logic [SEG_W-1:0]    segment_pins;
        logic                locked_pulse;
        logic                scan_busy;
        logic                scan_done;
    } t_out_item;

    typedef struct packed {
        logic [BAND_W-1:0]    band_index;
        logic [CHAN_W-1:0]    channel_index;
        logic [BAND_W-1:0]    band_pin_levels;
        logic [CHAN_W-1:0]    channel_pin_levels;
        logic [SEG_W-1:0]     segment_levels;
        logic [ELAPSED_W-1:0] band_elapsed;
        logic [ELAPSED_W-1:0] channel_elapsed;
        logic                 scanning;
        logic [CHAN_W-1:0]    scan_position;
        logic [RSSI_W-1:0]    best_strength;
        logic [CHAN_W-1:0]    best_position;
    } t_state;

    localparam t_state STATE_RESET = '{
        band_index:         '0,
        channel_index:      '0,
        band_pin_levels:    '0,
        channel_pin_levels: 3'd2,
        segment_levels:     '0,
        band_elapsed:       '0,
        channel_elapsed:    '0,
        scanning:           1'b0,
        scan_position:      '0,
        best_strength:      '0,
        best_position:      '0
    };

    // Active-low segment pattern that shows channel index plus one.
    function automatic logic [SEG_W-1:0] seg_code(input logic [CHAN_W-1:0] ch);
        logic [SEG_W-1:0] code;
        unique case (ch)
            3'd0: code = 7'h79;
            3'd1: code = 7'h24;
            3'd2: code = 7'h30;
            3'd3: code = 7'h19;
            3'd4: code = 7'h12;
            3'd5: code = 7'h02;
            3'd6: code = 7'h78;
            3'd7: code = 7'h00;
        endcase
        return code;
    endfunction

    // Band switch levels for each band index.
    function automatic logic [BAND_W-1:0] band_code(input logic [BAND_W-1:0] band);
        logic [BAND_W-1:0] code;
        unique case (band)
            2'd0: code = 2'd3;
            2'd1: code = 2'd0;
            2'd2: code = 2'd1;
            2'd3: code = 2'd2;
        endcase
        return code;
    endfunction

endpackage

[rtl/rfcs_if.sv]
// Handshake interfaces for the RF channel selector: event input, result
// output and the lockout configuration write channel. Depends on rfcs_pkg.
interface rfcs_in_if
    import rfcs_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rfcs_out_if
    import rfcs_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rfcs_cfg_if
    import rfcs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] wdata;
    modport source (output valid, output wdata, input ready);
    modport sink   (input valid, input wdata, output ready);
endinterface

[rtl/rf_channel_selector_with_scan_core.sv]
// Top level of the RF band and channel selector with RSSI scan.
// Depends on rfcs_pkg, the interfaces in rfcs_if and rfcs_update.
//
//  Channel   Direction  Payload                                  Transaction
//  i_in      sink       action, lock_switch, rssi_value          one event
//  o_out     source     band/channel/segment pins, flags         one result per event
//  i_cfg     sink       wdata = lockout_ms (16 bit)              one register write
//
// The result of each event is registered at the edge that accepts it and is
// offered on o_out in the next cycle. The output register is the only stage,
// so a new event is accepted in every cycle as long as the
// result register is empty or is being emptied in the same cycle. A stall on
// o_out holds the result, and i_in.ready is low in every cycle in which a held
// result is not taken. The synchronous active-low reset restores all selector
// state and sets lockout_ms to 200.
// Configuration writes are always taken.
module rf_channel_selector_with_scan_core
    import rfcs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rfcs_in_if.sink      i_in,
    rfcs_out_if.source   o_out,
    rfcs_cfg_if.sink     i_cfg
);

    // Selector state: band and channel, lockout counters and scan progress.
    t_state               r_state;
    t_state               n_state;
    logic [ELAPSED_W-1:0] r_lockout;

    // Result register that decouples the output handshake from the input.
    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;

    logic                 in_ready;
    logic                 in_fire;

    assign in_ready = !r_out_valid || o_out.ready;
    assign in_fire  = i_in.valid && in_ready;

    assign i_in.ready    = in_ready;
    assign i_cfg.ready   = 1'b1;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // All the work for one event: lockout checks, stepping and scan tracking.
    rfcs_update u_update (
        .i_state   (r_state),
        .i_item    (i_in.payload),
        .i_lockout (r_lockout),
        .o_state   (n_state),
        .o_result  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_lockout   <= LOCKOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_lockout <= i_cfg.wdata;
            end
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/rfcs_update.sv]
// Next-state and result logic for one event of the channel selector.
// Purely combinational; depends on rfcs_pkg.
module rfcs_update
    import rfcs_pkg::*;
(
    input  t_state               i_state,
    input  t_in_item             i_item,
    input  logic [ELAPSED_W-1:0] i_lockout,
    output t_state               o_state,
    output t_out_item            o_result
);

    t_state            nx;
    logic              locked;
    logic              done;
    logic [RSSI_W-1:0] best_s;
    logic [CHAN_W-1:0] best_p;

    always_comb begin
        nx     = i_state;
        locked = 1'b0;
        done   = 1'b0;
        best_s = i_state.best_strength;
        best_p = i_state.best_position;
        unique case (i_item.action)
            ACT_TICK: begin
                if (i_state.band_elapsed != ELAPSED_MAX) begin
                    nx.band_elapsed = i_state.band_elapsed + 16'd1;
                end
                if (i_state.channel_elapsed != ELAPSED_MAX) begin
                    nx.channel_elapsed = i_state.channel_elapsed + 16'd1;
                end
            end
            ACT_BAND: begin
                if (!i_state.scanning && (i_state.band_elapsed > i_lockout)) begin
                    nx.band_elapsed = '0;
                    if (!i_item.lock_switch) begin
                        locked = 1'b1;
                    end else begin
                        nx.band_index         = i_state.band_index + 2'd1;
                        nx.band_pin_levels    = band_code(nx.band_index);
                        nx.scanning           = 1'b1;
                        nx.scan_position      = '0;
                        nx.best_strength      = '0;
                        nx.best_position      = '0;
                        nx.channel_pin_levels = '0;
                    end
                end
            end
            ACT_CHAN: begin
                if (!i_state.scanning && (i_state.channel_elapsed > i_lockout)) begin
                    nx.channel_elapsed = '0;
                    if (!i_item.lock_switch) begin
                        locked = 1'b1;
                    end else begin
                        nx.channel_index      = i_state.channel_index + 3'd1;
                        nx.channel_pin_levels = nx.channel_index;
                        nx.segment_levels     = seg_code(nx.channel_index);
                    end
                end
            end
            ACT_RSSI: begin
                if (i_state.scanning) begin
                    // Strictly greater wins, so ties keep the earlier channel.
                    if (i_item.rssi_value > i_state.best_strength) begin
                        best_s = i_item.rssi_value;
                        best_p = i_state.scan_position;
                    end
                    nx.best_strength = best_s;
                    nx.best_position = best_p;
                    if (i_state.scan_position == SCAN_LAST) begin
                        nx.scanning           = 1'b0;
                        done                  = 1'b1;
                        nx.channel_index      = best_p;
                        nx.channel_pin_levels = best_p;
                        nx.segment_levels     = seg_code(best_p);
                    end else begin
                        nx.scan_position      = i_state.scan_position + 3'd1;
                        nx.channel_pin_levels = nx.scan_position;
                    end
                end
            end
        endcase
    end

    assign o_state               = nx;
    assign o_result.band_pins    = nx.band_pin_levels;
    assign o_result.channel_pins = nx.channel_pin_levels;
    assign o_result.segment_pins = nx.segment_levels;
    assign o_result.locked_pulse = locked;
    assign o_result.scan_busy    = nx.scanning;
    assign o_result.scan_done    = done;

endmodule

[rtl/rfcs_checker.sv]
// Port-level assertions for the RF channel selector, attached to the top level
// by the bind statement below. Depends on rfcs_pkg.
module rfcs_checker
    import rfcs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_item
);

    // A reset always empties the result register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result still offered after reset");

    // A stalled result keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("stalled result changed");

    // The final sample of a scan leaves the scan idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.scan_done |-> !i_out_item.scan_busy)
        else $error("scan reported done while still busy");

    // A refused press is never counted during a scan and never ends one.
    a_locked_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.locked_pulse
            |-> !i_out_item.scan_busy && !i_out_item.scan_done)
        else $error("locked press reported together with scan activity");

    // An accepted event always yields a result in the next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted event produced no result");

endmodule

bind rf_channel_selector_with_scan_core rfcs_checker u_rfcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.payload)
);
